// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/sprm_pkg.sv =====
// ---------------------------------------------------------------------------
// SPI register access master package
// Request codes and the result record shared by the core and output buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package sprm_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam int unsigned HEADER_BITS = 8;
	localparam int unsigned PORT_DATA_W = 24;
	localparam int unsigned HALF_W      = 16;

	localparam logic [HALF_W-1:0] HALF_RESET = 16'd50;

	typedef struct packed {
		logic                   chip_select_n;
		logic                   serial_clock;
		logic                   serial_out;
		logic                   busy_res;
		logic                   done_res;
		logic [PORT_DATA_W-1:0] read_value;
		logic                   rejected;
	} sprm_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sprm_core.sv =====
// ---------------------------------------------------------------------------
// SPI register access master core
// Input register, frame sequencer state and the per-tick next-state logic.
// ---------------------------------------------------------------------------
`default_nettype none

module sprm_core #(
	parameter int unsigned DATA_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          req_type,
	input  wire logic [6:0]                          reg_addr,
	input  wire logic [sprm_pkg::PORT_DATA_W-1:0]    write_data,
	input  wire logic                                miso_level,
	input  wire logic                                cfg_we,
	input  wire logic [sprm_pkg::HALF_W-1:0]         cfg_wdata,
	input  wire logic                                res_ready,
	output logic                                     res_push,
	output sprm_pkg::sprm_result_t                   res_data
);

	localparam int unsigned FRAME_BITS = sprm_pkg::HEADER_BITS + DATA_BITS;
	localparam int unsigned BC_W       = $clog2(FRAME_BITS + 1);
	localparam int unsigned WD_W       = (DATA_BITS < sprm_pkg::PORT_DATA_W) ?
		DATA_BITS : sprm_pkg::PORT_DATA_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BEGIN,
		PH_SELECT,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_DESELECT,
		PH_RELEASE
	} phase_t;

	logic                                 s1_valid_q;
	logic [1:0]                           req_s1;
	logic [6:0]                           addr_s1;
	logic [sprm_pkg::PORT_DATA_W-1:0]     data_s1;
	logic                                 miso_s1;

	logic [sprm_pkg::HALF_W-1:0]          half_q;
	phase_t                               phase_q, phase_d;
	logic [BC_W-1:0]                      bit_count_q, bit_count_d;
	logic [FRAME_BITS-1:0]                out_shift_q, out_shift_d;
	logic [DATA_BITS-1:0]                 in_shift_q, in_shift_d;
	logic [sprm_pkg::HALF_W-1:0]          tick_q, tick_d;
	logic                                 read_mode_q, read_mode_d;
	logic                                 cs_q, cs_d, sclk_q, sclk_d, mosi_q, mosi_d;

	logic                                 step;
	logic                                 accept;
	logic                                 is_req;
	logic [sprm_pkg::HALF_W-1:0]          half_eff;
	logic                                 rej;
	logic                                 done;
	logic [BC_W-1:0]                      bc_inc;
	logic [DATA_BITS-1:0]                 data_ext;

	assign step     = s1_valid_q & res_ready;
	assign in_stall = s1_valid_q & ~res_ready;
	assign accept   = in_valid & ~in_stall;
	assign res_push = step;
	assign is_req   = (req_s1 == sprm_pkg::REQ_WRITE) || (req_s1 == sprm_pkg::REQ_READ);
	assign half_eff = (half_q == '0) ? sprm_pkg::HALF_W'(1) : half_q;
	assign bc_inc   = bit_count_q + BC_W'(1);
	assign data_ext = DATA_BITS'(data_s1[WD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept | (s1_valid_q & ~step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			addr_s1 <= reg_addr;
			data_s1 <= write_data;
			miso_s1 <= miso_level;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		tick_d      = tick_q;
		read_mode_d = read_mode_q;
		cs_d        = cs_q;
		sclk_d      = sclk_q;
		mosi_d      = mosi_q;
		rej         = 1'b0;
		done        = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (is_req) begin
				read_mode_d = (req_s1 == sprm_pkg::REQ_READ);
				if (req_s1 == sprm_pkg::REQ_READ) begin
					out_shift_d = {1'b1, addr_s1, {DATA_BITS{1'b0}}};
					in_shift_d  = '0;
				end else begin
					out_shift_d = {1'b0, addr_s1, data_ext};
				end
				bit_count_d = '0;
				tick_d      = sprm_pkg::HALF_W'(1);
				phase_d     = PH_BEGIN;
				cs_d        = 1'b1;
				sclk_d      = 1'b0;
				mosi_d      = 1'b1;
			end
		end else begin
			rej = is_req;
			if (tick_q < half_eff) begin
				tick_d = tick_q + sprm_pkg::HALF_W'(1);
			end else begin
				tick_d = sprm_pkg::HALF_W'(1);
				case (phase_q)
					PH_BEGIN: begin
						phase_d = PH_SELECT;
						cs_d    = 1'b0;
					end
					PH_SELECT: begin
						phase_d = PH_BIT_LOW;
						sclk_d  = 1'b0;
						if (!(read_mode_q && bit_count_q >= BC_W'(sprm_pkg::HEADER_BITS))) begin
							mosi_d      = out_shift_q[FRAME_BITS-1];
							out_shift_d = {out_shift_q[FRAME_BITS-2:0], 1'b0};
						end
					end
					PH_BIT_LOW: begin
						if (read_mode_q && bit_count_q >= BC_W'(sprm_pkg::HEADER_BITS)) begin
							in_shift_d = {in_shift_q[DATA_BITS-2:0], miso_s1};
						end
						phase_d = PH_BIT_HIGH;
						sclk_d  = 1'b1;
					end
					PH_BIT_HIGH: begin
						bit_count_d = bc_inc;
						if (bc_inc >= BC_W'(FRAME_BITS)) begin
							phase_d = PH_DESELECT;
							sclk_d  = 1'b0;
							cs_d    = 1'b1;
						end else begin
							phase_d = PH_BIT_LOW;
							sclk_d  = 1'b0;
							if (!(read_mode_q && bc_inc >= BC_W'(sprm_pkg::HEADER_BITS))) begin
								mosi_d      = out_shift_q[FRAME_BITS-1];
								out_shift_d = {out_shift_q[FRAME_BITS-2:0], 1'b0};
							end
						end
					end
					PH_DESELECT: begin
						phase_d = PH_RELEASE;
						sclk_d  = 1'b1;
						mosi_d  = 1'b1;
					end
					PH_RELEASE: begin
						phase_d     = PH_IDLE;
						tick_d      = '0;
						bit_count_d = '0;
						done        = 1'b1;
					end
					default: begin
						phase_d     = PH_IDLE;
						tick_d      = '0;
						bit_count_d = '0;
						cs_d        = 1'b1;
						sclk_d      = 1'b1;
						mosi_d      = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		res_data.chip_select_n = cs_d;
		res_data.serial_clock  = sclk_d;
		res_data.serial_out    = mosi_d;
		res_data.busy_res      = (phase_d != PH_IDLE);
		res_data.done_res      = done;
		res_data.read_value    = sprm_pkg::PORT_DATA_W'(in_shift_d[WD_W-1:0]);
		res_data.rejected      = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= sprm_pkg::HALF_RESET;
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			tick_q      <= '0;
			read_mode_q <= 1'b0;
			cs_q        <= 1'b1;
			sclk_q      <= 1'b1;
			mosi_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				half_q <= cfg_wdata;
			end
			if (step) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				out_shift_q <= out_shift_d;
				in_shift_q  <= in_shift_d;
				tick_q      <= tick_d;
				read_mode_q <= read_mode_d;
				cs_q        <= cs_d;
				sclk_q      <= sclk_d;
				mosi_q      <= mosi_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sprm_out_buf.sv =====
// ---------------------------------------------------------------------------
// SPI register access master output buffer
// Result register with a skid entry; the core waits only once the skid entry is full.
// ---------------------------------------------------------------------------
`default_nettype none

module sprm_out_buf (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire sprm_pkg::sprm_result_t push_data,
	output logic                        ready,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output sprm_pkg::sprm_result_t      out_data
);

	logic                   out_valid_q;
	logic                   skid_valid_q;
	sprm_pkg::sprm_result_t out_q;
	sprm_pkg::sprm_result_t skid_q;
	logic                   out_free;

	assign ready     = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_register_access_master.sv =====
// ---------------------------------------------------------------------------
// SPI register access master
// Register-access SPI master advanced by one tick for every input transfer.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_stall    req_type, reg_addr, write_data, miso_level
//  result   out_valid / out_stall  chip_select_n, serial_clock, serial_out,
//                                  busy_res, done_res, read_value, rejected
//  config   cfg_we                 cfg_wdata (half period in ticks)
//
// Each input transfer is one tick; it and its one result transfer are registered.
// One transfer is taken every cycle unless stalled; the tick update is a single
// pass in the core. Reset selects idle with all pins high and a half period of
// fifty ticks. A result stall fills the skid entry, after which input is stalled.
`default_nettype none

module spi_register_access_master #(
	parameter int unsigned DATA_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       req_type,
	input  wire logic [6:0]                       reg_addr,
	input  wire logic [sprm_pkg::PORT_DATA_W-1:0] write_data,
	input  wire logic                             miso_level,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  chip_select_n,
	output logic                                  serial_clock,
	output logic                                  serial_out,
	output logic                                  busy_res,
	output logic                                  done_res,
	output logic [sprm_pkg::PORT_DATA_W-1:0]      read_value,
	output logic                                  rejected,
	input  wire logic                             cfg_we,
	input  wire logic [sprm_pkg::HALF_W-1:0]      cfg_wdata
);

	logic                   res_ready;
	logic                   res_push;
	sprm_pkg::sprm_result_t res_data;
	sprm_pkg::sprm_result_t out_data;

	sprm_core #(
		.DATA_BITS(DATA_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.miso_level (miso_level),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_ready  (res_ready),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	sprm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.ready     (res_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign chip_select_n = out_data.chip_select_n;
	assign serial_clock  = out_data.serial_clock;
	assign serial_out    = out_data.serial_out;
	assign busy_res      = out_data.busy_res;
	assign done_res      = out_data.done_res;
	assign read_value    = out_data.read_value;
	assign rejected      = out_data.rejected;

endmodule

`default_nettype wire

// ===== hw/rtl/sprm_checker.sv =====
// ---------------------------------------------------------------------------
// SPI register access master checker
// Port-level properties of the master, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sprm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic                             done_res,
	input wire logic [sprm_pkg::PORT_DATA_W-1:0] read_value
);

	`SPRM_ASSERT_IMPL(a_accept_to_result, clk, arst_n, in_valid && !in_stall, ##2 out_valid)
	`SPRM_ASSERT_IMPL(a_stall_needs_result, clk, arst_n, in_stall, out_valid)
	`SPRM_ASSERT_NEXT(a_valid_holds, clk, arst_n, out_valid && out_stall, out_valid)
	`SPRM_ASSERT_NEXT(a_payload_holds, clk, arst_n, out_valid && out_stall, $stable(read_value) && $stable(done_res))

endmodule

bind spi_register_access_master sprm_checker u_sprm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.done_res   (done_res),
	.read_value (read_value)
);

`default_nettype wire
